FILE: rtl/sshd_pkg.sv
// ----------------------------------------------------------------------------
// sshd_pkg
// shared types and constants of the ssh binary packet deframer
// ----------------------------------------------------------------------------
package sshd_pkg;

   localparam logic [15:0] MAX_PACKET_LEN_RESET = 16'd35000;
   localparam logic [15:0] PAYLOAD_LIMIT_RESET  = 16'd4096;
   localparam logic [15:0] MIN_PACKET_LEN       = 16'd5;

   // csr register indexes
   localparam logic REG_MAX_PACKET_LEN = 1'b0;
   localparam logic REG_PAYLOAD_LIMIT  = 1'b1;

   // error codes
   localparam logic [1:0] ERR_NONE        = 2'd0;
   localparam logic [1:0] ERR_BAD_LENGTH  = 2'd1;
   localparam logic [1:0] ERR_PAD_TOO_LONG = 2'd2;
   localparam logic [1:0] ERR_OVER_LIMIT  = 2'd3;

   // parser phases
   localparam logic [2:0] PH_LENGTH  = 3'd0;
   localparam logic [2:0] PH_PADLEN  = 3'd1;
   localparam logic [2:0] PH_PAYLOAD = 3'd2;
   localparam logic [2:0] PH_PADDING = 3'd3;
   localparam logic [2:0] PH_DEAD    = 3'd4;

   typedef struct packed {
      logic [15:0] max_packet_len;
      logic [15:0] payload_limit;
   } cfg_type;

   typedef struct packed {
      logic        has_byte;
      logic [7:0]  payload_byte;
      logic        last_payload;
      logic        packet_end;
      logic [15:0] payload_length;
      logic [1:0]  error_code;
   } result_type;

endpackage

FILE: rtl/sshd_if.sv
// ----------------------------------------------------------------------------
// sshd request and response channels
// valid/ready channels carrying stream bytes in and deframed results out
// ----------------------------------------------------------------------------
interface sshd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface sshd_rsp_if;
   logic        valid;
   logic        ready;
   logic        has_byte;
   logic [7:0]  payload_byte;
   logic        last_payload;
   logic        packet_end;
   logic [15:0] payload_length;
   logic [1:0]  error_code;

   modport source (output valid, output has_byte, output payload_byte,
                   output last_payload, output packet_end,
                   output payload_length, output error_code, input ready);
   modport sink (input valid, input has_byte, input payload_byte,
                 input last_payload, input packet_end,
                 input payload_length, input error_code, output ready);
endinterface

FILE: rtl/sshd_csr.sv
// ----------------------------------------------------------------------------
// sshd_csr
// apb register file holding the length limits
// ----------------------------------------------------------------------------
module sshd_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   output sshd_pkg::cfg_type  cfg
);

   logic [15:0] max_len_ff;
   logic [15:0] max_len_in;
   logic [15:0] pay_lim_ff;
   logic [15:0] pay_lim_in;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      max_len_in = max_len_ff;
      pay_lim_in = pay_lim_ff;
      if (wr_en) begin
         case (paddr[2])
            sshd_pkg::REG_MAX_PACKET_LEN: max_len_in = pwdata[15:0];
            sshd_pkg::REG_PAYLOAD_LIMIT:  pay_lim_in = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= sshd_pkg::MAX_PACKET_LEN_RESET;
         pay_lim_ff <= sshd_pkg::PAYLOAD_LIMIT_RESET;
      end else begin
         max_len_ff <= max_len_in;
         pay_lim_ff <= pay_lim_in;
      end
   end

   always_comb begin
      case (paddr[2])
         sshd_pkg::REG_MAX_PACKET_LEN: prdata = {16'd0, max_len_ff};
         sshd_pkg::REG_PAYLOAD_LIMIT:  prdata = {16'd0, pay_lim_ff};
         default:                      prdata = 32'd0;
      endcase
   end

   assign cfg.max_packet_len = max_len_ff;
   assign cfg.payload_limit  = pay_lim_ff;

endmodule

FILE: rtl/sshd_parse.sv
// ----------------------------------------------------------------------------
// sshd_parse
// framing state machine: one stream byte per step, zero or one result
// ----------------------------------------------------------------------------
module sshd_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           rx_byte,
   input  sshd_pkg::cfg_type    cfg,
   output logic                 res_valid,
   output sshd_pkg::result_type res
);

   logic [2:0]  phase_ff;
   logic [2:0]  phase_in;
   logic [15:0] len_lo_ff;
   logic [15:0] len_lo_in;
   logic        len_hi_ff;
   logic        len_hi_in;
   logic [15:0] pkt_len_ff;
   logic [15:0] pkt_len_in;
   logic [7:0]  pad_ff;
   logic [7:0]  pad_in;
   logic [15:0] cnt_ff;
   logic [15:0] cnt_in;
   logic [15:0] pay_cnt_ff;
   logic [15:0] pay_cnt_in;
   logic [15:0] cnt_next;
   logic [15:0] pay_len;

   assign cnt_next = cnt_ff + 16'd1;
   assign pay_len  = pkt_len_ff - 16'd1 - {8'd0, rx_byte};

   always_comb begin
      phase_in   = phase_ff;
      len_lo_in  = len_lo_ff;
      len_hi_in  = len_hi_ff;
      pkt_len_in = pkt_len_ff;
      pad_in     = pad_ff;
      cnt_in     = cnt_ff;
      pay_cnt_in = pay_cnt_ff;
      res_valid  = 1'b0;
      res        = '0;
      case (phase_ff)
         sshd_pkg::PH_LENGTH: begin
            // low 16 bits plus a sticky flag for anything above them
            len_lo_in = {len_lo_ff[7:0], rx_byte};
            len_hi_in = len_hi_ff | (len_lo_ff[15:8] != 8'd0);
            cnt_in    = cnt_next;
            if (cnt_ff == 16'd3) begin
               if (len_hi_in || (len_lo_in < sshd_pkg::MIN_PACKET_LEN) ||
                   (len_lo_in > cfg.max_packet_len)) begin
                  phase_in       = sshd_pkg::PH_DEAD;
                  res_valid      = 1'b1;
                  res.error_code = sshd_pkg::ERR_BAD_LENGTH;
               end else begin
                  pkt_len_in = len_lo_in;
                  cnt_in     = 16'd0;
                  phase_in   = sshd_pkg::PH_PADLEN;
               end
            end
         end
         sshd_pkg::PH_PADLEN: begin
            pad_in = rx_byte;
            if ({8'd0, rx_byte} >= (pkt_len_ff - 16'd1)) begin
               phase_in       = sshd_pkg::PH_DEAD;
               res_valid      = 1'b1;
               res.error_code = sshd_pkg::ERR_PAD_TOO_LONG;
            end else if (pay_len > cfg.payload_limit) begin
               pay_cnt_in     = pay_len;
               phase_in       = sshd_pkg::PH_DEAD;
               res_valid      = 1'b1;
               res.error_code = sshd_pkg::ERR_OVER_LIMIT;
            end else begin
               pay_cnt_in = pay_len;
               cnt_in     = 16'd0;
               phase_in   = sshd_pkg::PH_PAYLOAD;
            end
         end
         sshd_pkg::PH_PAYLOAD: begin
            res_valid        = 1'b1;
            res.has_byte     = 1'b1;
            res.payload_byte = rx_byte;
            cnt_in           = cnt_next;
            if (cnt_next >= pay_cnt_ff) begin
               res.last_payload = 1'b1;
               if (pad_ff == 8'd0) begin
                  res.packet_end     = 1'b1;
                  res.payload_length = pay_cnt_ff;
                  phase_in   = sshd_pkg::PH_LENGTH;
                  len_lo_in  = 16'd0;
                  len_hi_in  = 1'b0;
                  pkt_len_in = 16'd0;
                  pad_in     = 8'd0;
                  cnt_in     = 16'd0;
                  pay_cnt_in = 16'd0;
               end else begin
                  cnt_in   = 16'd0;
                  phase_in = sshd_pkg::PH_PADDING;
               end
            end
         end
         sshd_pkg::PH_PADDING: begin
            cnt_in = cnt_next;
            if (cnt_next >= {8'd0, pad_ff}) begin
               res_valid          = 1'b1;
               res.packet_end     = 1'b1;
               res.payload_length = pay_cnt_ff;
               phase_in   = sshd_pkg::PH_LENGTH;
               len_lo_in  = 16'd0;
               len_hi_in  = 1'b0;
               pkt_len_in = 16'd0;
               pad_in     = 8'd0;
               cnt_in     = 16'd0;
               pay_cnt_in = 16'd0;
            end
         end
         default: ;  // dead: input ignored until reset
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= sshd_pkg::PH_LENGTH;
         len_lo_ff  <= 16'd0;
         len_hi_ff  <= 1'b0;
         pkt_len_ff <= 16'd0;
         pad_ff     <= 8'd0;
         cnt_ff     <= 16'd0;
         pay_cnt_ff <= 16'd0;
      end else if (step) begin
         phase_ff   <= phase_in;
         len_lo_ff  <= len_lo_in;
         len_hi_ff  <= len_hi_in;
         pkt_len_ff <= pkt_len_in;
         pad_ff     <= pad_in;
         cnt_ff     <= cnt_in;
         pay_cnt_ff <= pay_cnt_in;
      end
   end

   a_dead_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == sshd_pkg::PH_DEAD |=> phase_ff == sshd_pkg::PH_DEAD)
      else $error("parser left the error phase");

   a_dead_quiet: assert property (@(posedge clock) disable iff (reset)
      phase_ff == sshd_pkg::PH_DEAD |-> !res_valid)
      else $error("result produced after an error");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      res_valid && (res.error_code != sshd_pkg::ERR_NONE) |->
         !res.has_byte && !res.packet_end && (res.payload_length == 16'd0))
      else $error("error report carries data");

   a_end_len: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.packet_end |-> res.payload_length != 16'd0)
      else $error("packet end with zero payload length");

endmodule

FILE: rtl/ssh_binary_packet_deframer_top.sv
// ----------------------------------------------------------------------------
// ssh_binary_packet_deframer_top
// splits a received byte stream into plaintext ssh binary packets
// a byte's result passes through the input register and then the result register
// throughput: one byte per cycle, set by the single-step framing state machine
// a cycle with no request or a stalled result slot simply holds the pipeline
// reset (synchronous, active high) restores limits 35000/4096 and restarts
// length collection; after any error, bytes are dropped until reset
// ----------------------------------------------------------------------------
module ssh_binary_packet_deframer_top (
   input  logic         clock,
   input  logic         reset,
   sshd_req_if.sink     req_chan,
   sshd_rsp_if.source   rsp_chan,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   sshd_pkg::cfg_type    cfg;
   sshd_pkg::result_type step_res;
   sshd_pkg::result_type out_res_ff;
   sshd_pkg::result_type out_res_in;

   // input register stage
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic [7:0] in_byte_in;

   // result register stage
   logic       out_valid_ff;
   logic       out_valid_in;

   logic       out_free;
   logic       step;
   logic       step_valid;

   // limits from the apb register file
   sshd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // result slot frees up when empty or being drained this cycle
   assign out_free = !out_valid_ff || rsp_chan.ready;
   // the held byte is framed when its result (if any) has a place to go
   assign step     = in_valid_ff && out_free;

   // input stage takes a new request whenever its byte moves on
   assign req_chan.ready = !in_valid_ff || out_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         in_byte_in  = req_chan.rx_byte;
      end
   end

   sshd_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rx_byte   (in_byte_ff),
      .cfg       (cfg),
      .res_valid (step_valid),
      .res       (step_res)
   );

   // quiet bytes (length, pad length, padding) leave the slot empty
   always_comb begin
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (out_free) begin
         out_valid_in = step && step_valid;
         out_res_in   = step_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers need no reset
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.has_byte       = out_res_ff.has_byte;
   assign rsp_chan.payload_byte   = out_res_ff.payload_byte;
   assign rsp_chan.last_payload   = out_res_ff.last_payload;
   assign rsp_chan.packet_end     = out_res_ff.packet_end;
   assign rsp_chan.payload_length = out_res_ff.payload_length;
   assign rsp_chan.error_code     = out_res_ff.error_code;

endmodule

FILE: tb/ssh_binary_packet_deframer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssh_binary_packet_deframer_top_test
// self-checking bench for the ssh binary packet deframer: drives stream bytes
// and limit registers, predicts every deframed result and checks each one
// ----------------------------------------------------------------------------
module ssh_binary_packet_deframer_top_test;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int QUIET_CYCLES = 8;     // margin for the pipeline to empty after the last result
   localparam int HOLD_CYCLES  = 150;   // long receiver hold-off for the fill-up test
   localparam int RANDOM_BYTES = 500;

   typedef enum {
      FAULT_SHORT_LENGTH,
      FAULT_OVERSIZE_LENGTH,
      FAULT_TINY_MAX_LEN,
      FAULT_PAD_TOO_LONG,
      FAULT_OVER_LIMIT,
      FAULT_ZERO_LIMIT
   } closing_fault_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   sshd_req_if req_chan ();
   sshd_rsp_if rsp_chan ();

   ssh_binary_packet_deframer_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // predictor copy of the parser state and the limit registers
   sshd_pkg::cfg_type limits;
   logic [2:0]  parse_phase;
   logic [31:0] length_acc;
   logic [15:0] pkt_len;
   logic [7:0]  pad_len;
   logic [15:0] step_count;
   logic [15:0] body_len;

   sshd_pkg::result_type deframed_due[$];   // results predicted but not yet seen

   int unsigned failures;
   int unsigned bytes_taken;
   int unsigned results_checked;
   int unsigned packets_closed;
   int unsigned payload_bytes;
   int unsigned registers_written;
   int unsigned cycle_count;
   bit          steady_stream;     // both sides stop idling while set
   bit          hold_request;      // asks the receiver for one long hold-off
   closing_fault_type fault_kind;

   // ------------------------------------------------------------------------
   // clock and watchdog
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results still due",
               cycle_count, deframed_due.size());
      $display("status: fail");
      $finish;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic void restart_framing();
      parse_phase = sshd_pkg::PH_LENGTH;
      length_acc  = '0;
      pkt_len     = '0;
      pad_len     = '0;
      step_count  = '0;
      body_len    = '0;
   endfunction

   // advance the parser by one accepted byte, queue whatever result it gives
   function automatic void deframe_byte(input logic [7:0] b);
      sshd_pkg::result_type r;
      r = '0;
      case (parse_phase)
         sshd_pkg::PH_LENGTH: begin
            length_acc = {length_acc[23:0], b};
            step_count++;
            if (step_count == 16'd4) begin
               if (length_acc < sshd_pkg::MIN_PACKET_LEN ||
                   length_acc > limits.max_packet_len) begin
                  // bad length is reported on the fourth length byte
                  parse_phase = sshd_pkg::PH_DEAD;
                  r.error_code = sshd_pkg::ERR_BAD_LENGTH;
                  deframed_due.push_back(r);
               end else begin
                  pkt_len     = length_acc[15:0];
                  step_count  = '0;
                  parse_phase = sshd_pkg::PH_PADLEN;
               end
            end
         end
         sshd_pkg::PH_PADLEN: begin
            pad_len = b;
            if (pad_len >= pkt_len - 16'd1) begin
               parse_phase = sshd_pkg::PH_DEAD;
               r.error_code = sshd_pkg::ERR_PAD_TOO_LONG;
               deframed_due.push_back(r);
            end else begin
               body_len = pkt_len - 16'd1 - pad_len;
               // limit is taken at the moment of this check
               if (body_len > limits.payload_limit) begin
                  parse_phase = sshd_pkg::PH_DEAD;
                  r.error_code = sshd_pkg::ERR_OVER_LIMIT;
                  deframed_due.push_back(r);
               end else begin
                  step_count  = '0;
                  parse_phase = sshd_pkg::PH_PAYLOAD;
               end
            end
         end
         sshd_pkg::PH_PAYLOAD: begin
            step_count++;
            r.has_byte     = 1'b1;
            r.payload_byte = b;
            if (step_count >= body_len) begin
               r.last_payload = 1'b1;
               if (pad_len == 8'd0) begin
                  // no padding: last payload byte also closes the packet
                  r.packet_end     = 1'b1;
                  r.payload_length = body_len;
                  restart_framing();
               end else begin
                  step_count  = '0;
                  parse_phase = sshd_pkg::PH_PADDING;
               end
            end
            deframed_due.push_back(r);
         end
         sshd_pkg::PH_PADDING: begin
            step_count++;
            if (step_count >= pad_len) begin
               r.packet_end     = 1'b1;
               r.payload_length = body_len;
               deframed_due.push_back(r);
               restart_framing();
            end
         end
         default: ;   // dead after an error, bytes vanish
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------------
   function automatic void note_failure(input string what);
      failures++;
      if (failures <= 10)
         $display("mismatch at cycle %0d: %s", cycle_count, what);
   endfunction

   function automatic string describe(input sshd_pkg::result_type r);
      return $sformatf("has_byte=%0d byte=%02h last=%0d end=%0d length=%0d error=%0d",
                       r.has_byte, r.payload_byte, r.last_payload, r.packet_end,
                       r.payload_length, r.error_code);
   endfunction

   function automatic void compare_field(input string field, input logic [15:0] want,
                                         input logic [15:0] got);
      if (got !== want)
         note_failure($sformatf("result %0d %s expected %0h got %0h",
                                results_checked, field, want, got));
   endfunction

   always @(posedge clock) begin : check_results
      sshd_pkg::result_type seen;
      sshd_pkg::result_type want;
      if (reset === 1'b0 && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         seen.has_byte       = rsp_chan.has_byte;
         seen.payload_byte   = rsp_chan.payload_byte;
         seen.last_payload   = rsp_chan.last_payload;
         seen.packet_end     = rsp_chan.packet_end;
         seen.payload_length = rsp_chan.payload_length;
         seen.error_code     = rsp_chan.error_code;
         if (deframed_due.size() == 0) begin
            note_failure({"unexpected result ", describe(seen)});
         end else begin
            want = deframed_due.pop_front();
            compare_field("has_byte", 16'(want.has_byte), 16'(seen.has_byte));
            compare_field("payload_byte", 16'(want.payload_byte),
                          16'(seen.payload_byte));
            compare_field("last_payload", 16'(want.last_payload),
                          16'(seen.last_payload));
            compare_field("packet_end", 16'(want.packet_end), 16'(seen.packet_end));
            compare_field("payload_length", want.payload_length, seen.payload_length);
            compare_field("error_code", 16'(want.error_code), 16'(seen.error_code));
            if (want.packet_end)
               packets_closed++;
            if (want.has_byte)
               payload_bytes++;
         end
         results_checked++;
      end
   end

   // ------------------------------------------------------------------------
   // receiver: random stall before each result, one long hold-off on request
   // ------------------------------------------------------------------------
   initial begin : result_receiver
      int unsigned stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            stall = HOLD_CYCLES;
            hold_request = 1'b0;
         end else begin
            stall = steady_stream ? 0 : $urandom_range(0, 12);
         end
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
      end
   end

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   // offer one stream byte after a random gap; valid stays high when the next
   // gap is zero so back-to-back requests never toggle it within a step
   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      gap = steady_stream ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      bytes_taken++;
      deframe_byte(b);
   endtask

   task automatic send_length(input logic [31:0] len);
      for (int i = 3; i >= 0; i--)
         send_byte(len[8*i +: 8]);
   endtask

   task automatic send_framed_packet(input int body, input int pad);
      send_length(32'(body + 1 + pad));
      send_byte(8'(pad));
      repeat (body) send_byte(8'($urandom));
      repeat (pad) send_byte(8'($urandom));
   endtask

   // well-formed packet inside the current limits; at_edge picks the largest
   // payload that the limits and cap allow, and the largest padding that still fits
   task automatic send_fitting_packet(input int cap, input bit at_edge);
      int body_max;
      int body;
      int pad_lo;
      int pad_hi;
      body_max = int'(limits.payload_limit);
      if (int'(limits.max_packet_len) - 1 < body_max)
         body_max = int'(limits.max_packet_len) - 1;
      if (cap < body_max)
         body_max = cap;
      body   = at_edge ? body_max : int'($urandom_range(1, body_max));
      pad_lo = (body < 4) ? 4 - body : 0;
      pad_hi = int'(limits.max_packet_len) - 1 - body;
      if (pad_hi > 255)
         pad_hi = 255;
      // mostly short padding, now and then a long dropped stretch
      if (!at_edge && $urandom_range(0, 9) != 0 && pad_hi > pad_lo + 8)
         pad_hi = pad_lo + 8;
      send_framed_packet(body, at_edge ? pad_hi : int'($urandom_range(pad_lo, pad_hi)));
   endtask

   // wait until every predicted result is in and the pipeline has emptied
   task automatic wait_quiet();
      req_chan.valid <= 1'b0;
      while (deframed_due.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // apb write with random upper data bits, then read back the low half
   task automatic write_register(input logic idx, input logic [15:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {16'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (idx == sshd_pkg::REG_MAX_PACKET_LEN)
         limits.max_packet_len = value;
      else
         limits.payload_limit = value;
      registers_written++;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata[15:0] !== value)
         note_failure($sformatf("register %0d read back %0h, written %0h",
                                idx, prdata[15:0], value));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // smallest legal packets: one payload byte followed by quiet padding, and
   // four payload bytes with no padding so the last one closes the packet
   task automatic test_minimum_packets();
      send_length(32'd5);
      send_byte(8'd3);
      send_byte(8'hff);
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'h00);
      send_length(32'd5);
      send_byte(8'd0);
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'h5a);
      send_byte(8'ha5);
      wait_quiet();
   endtask

   // limit pairs, mostly at the ends of their ranges, each with an edge-sized packet
   // (payload capped at 24) and two random fitting packets
   task automatic test_register_extremes();
      logic [15:0] max_set[5];
      logic [15:0] limit_set[5];
      max_set   = '{16'd65535, 16'd5, 16'd5, 16'd65535, 16'd20};
      limit_set = '{16'd65535, 16'd1, 16'd65535, 16'd1, 16'd12};
      for (int i = 0; i < 5; i++) begin
         write_register(sshd_pkg::REG_MAX_PACKET_LEN, max_set[i]);
         write_register(sshd_pkg::REG_PAYLOAD_LIMIT, limit_set[i]);
         send_fitting_packet(24, 1'b1);
         send_fitting_packet(24, 1'b0);
         send_fitting_packet(24, 1'b0);
         wait_quiet();
      end
   endtask

   // the payload limit is changed after the length check but before the
   // padding-length byte; the new value must be the one that counts
   task automatic test_limit_change_mid_packet();
      int pad;
      pad = $urandom_range(0, 10);
      write_register(sshd_pkg::REG_MAX_PACKET_LEN, 16'd65535);
      write_register(sshd_pkg::REG_PAYLOAD_LIMIT, 16'd1);
      send_length(32'd30);
      wait_quiet();   // length bytes give no result, so this only lets them settle
      write_register(sshd_pkg::REG_PAYLOAD_LIMIT, 16'(29 - pad));
      send_byte(8'(pad));
      repeat (29 - pad) send_byte(8'($urandom));
      repeat (pad) send_byte(8'($urandom));
      wait_quiet();
   endtask

   // long run of well-formed packets with random content, random sizes and a
   // new pair of limits every so often
   task automatic test_random_packets();
      int unsigned start_bytes;
      int          packet_no;
      logic [15:0] new_max;
      logic [15:0] new_limit;
      start_bytes = bytes_taken;
      packet_no   = 0;
      while (bytes_taken - start_bytes < RANDOM_BYTES) begin
         if (packet_no % 20 == 0) begin
            wait_quiet();
            case ($urandom_range(0, 3))
               0: new_max = 16'd5;
               1: new_max = 16'($urandom_range(5, 64));
               2: new_max = 16'($urandom_range(5, 65535));
               default: new_max = 16'd65535;
            endcase
            case ($urandom_range(0, 3))
               0: new_limit = 16'd1;
               1: new_limit = 16'($urandom_range(1, 32));
               2: new_limit = 16'($urandom_range(1, 65535));
               default: new_limit = 16'd65535;
            endcase
            write_register(sshd_pkg::REG_MAX_PACKET_LEN, new_max);
            write_register(sshd_pkg::REG_PAYLOAD_LIMIT, new_limit);
         end
         // alternate between bursts without idling and randomly gapped traffic
         if ($urandom_range(0, 7) == 0)
            steady_stream = ~steady_stream;
         send_fitting_packet(($urandom_range(0, 19) == 0) ? 300 : 24, 1'b0);
         packet_no++;
      end
      steady_stream = 1'b0;
      wait_quiet();
   endtask

   // receiver holds off for a long stretch while bytes keep coming, so the
   // block fills and has to push back on its input
   task automatic test_backpressure();
      write_register(sshd_pkg::REG_MAX_PACKET_LEN, 16'd65535);
      write_register(sshd_pkg::REG_PAYLOAD_LIMIT, 16'd4096);
      steady_stream = 1'b1;
      hold_request  = 1'b1;
      send_framed_packet(48, 2);
      send_framed_packet(6, 0);
      steady_stream = 1'b0;
      wait_quiet();
   endtask

   // an error locks the block until reset, and reset comes only once, so the
   // run ends with one randomly chosen error followed by ignored noise
   task automatic test_fatal_error();
      int body;
      int pad;
      int len;
      fault_kind = closing_fault_type'($urandom_range(0, 5));
      write_register(sshd_pkg::REG_MAX_PACKET_LEN, 16'd65535);
      write_register(sshd_pkg::REG_PAYLOAD_LIMIT, 16'd4096);
      case (fault_kind)
         FAULT_SHORT_LENGTH:
            send_length(32'($urandom_range(0, 4)));
         FAULT_OVERSIZE_LENGTH: begin
            write_register(sshd_pkg::REG_MAX_PACKET_LEN,
                           16'($urandom_range(5, 65534)));
            if ($urandom_range(0, 1) == 0)
               send_length(32'($urandom_range(int'(limits.max_packet_len) + 1, 65535)));
            else
               send_length({16'($urandom_range(1, 65535)), 16'($urandom)});
         end
         FAULT_TINY_MAX_LEN: begin
            // a maximum below five makes every length bad
            write_register(sshd_pkg::REG_MAX_PACKET_LEN, 16'($urandom_range(0, 4)));
            send_length(32'($urandom_range(5, 1000)));
         end
         FAULT_PAD_TOO_LONG: begin
            len = $urandom_range(5, 256);
            send_length(32'(len));
            send_byte(8'($urandom_range(len - 1, 255)));
         end
         FAULT_OVER_LIMIT: begin
            write_register(sshd_pkg::REG_PAYLOAD_LIMIT, 16'($urandom_range(1, 40)));
            body = int'(limits.payload_limit) + int'($urandom_range(1, 20));
            pad  = $urandom_range(4, 10);
            send_length(32'(body + 1 + pad));
            send_byte(8'(pad));
         end
         default: begin
            // a zero limit rejects every packet
            write_register(sshd_pkg::REG_PAYLOAD_LIMIT, 16'd0);
            body = $urandom_range(1, 20);
            pad  = $urandom_range(4, 10);
            send_length(32'(body + 1 + pad));
            send_byte(8'(pad));
         end
      endcase
      repeat (30) send_byte(8'($urandom));
      wait_quiet();
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      failures          = 0;
      bytes_taken       = 0;
      results_checked   = 0;
      packets_closed    = 0;
      payload_bytes     = 0;
      registers_written = 0;
      steady_stream     = 1'b0;
      hold_request      = 1'b0;
      fault_kind        = FAULT_SHORT_LENGTH;
      limits.max_packet_len = sshd_pkg::MAX_PACKET_LEN_RESET;
      limits.payload_limit  = sshd_pkg::PAYLOAD_LIMIT_RESET;
      restart_framing();

      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.rx_byte <= '0;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_minimum_packets();
      test_register_extremes();
      test_limit_change_mid_packet();
      test_random_packets();
      test_backpressure();
      test_fatal_error();

      if (deframed_due.size() != 0)
         note_failure($sformatf("%0d expected results never arrived",
                                deframed_due.size()));

      $display("deframer run: %0d stream bytes, %0d results, %0d packets, %0d payload bytes",
               bytes_taken, results_checked, packets_closed, payload_bytes);
      $display("%0d register writes, closing error case %s, %0d mismatches",
               registers_written, fault_kind.name(), failures);
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
